>>> hdl/percent_codec_unit_macros.svh
// Assertion macros shared by the percent codec checker.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef PERCENT_CODEC_UNIT_MACROS_SVH
`define PERCENT_CODEC_UNIT_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define PCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks a property at every clock edge, reset included.
`define PCT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> hdl/pct_pkg.sv
// Shared types, constants and helper functions of the percent codec.
// Depends on nothing; used by pct_convert, pct_expand, percent_codec_unit and the testbench.
package pct_pkg;

    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    localparam int unsigned SET_SLOTS = 8;
    localparam int unsigned MAX_RES   = 3;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INCLUDE = 2'd2;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PERCENT,
        PH_DIGIT
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] held;
    } t_state;

    typedef struct packed {
        logic [1:0]               cnt;
        logic [MAX_RES-1:0][7:0]  bytes;
        logic [MAX_RES-1:0]       lasts;
    } t_result;

    function automatic logic is_unreserved(input logic [7:0] b);
        return (b >= CH_LOWER_A && b <= CH_LOWER_Z) ||
               (b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
               (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) ||
               b == CH_DASH || b == CH_DOT || b == CH_UNDER || b == CH_TILDE;
    endfunction

    function automatic logic in_set(input logic [63:0] set, input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < SET_SLOTS; k++) begin
            if (set[8*k +: 8] == b) begin
                hit = 1'b1;
            end
        end
        return hit && (b != 8'h00);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return CH_DIGIT_0 + {4'h0, v};
        end
        return CH_UPPER_A + {4'h0, v} - 8'd10;
    endfunction

    function automatic logic [7:0] digit_value(input logic [7:0] b);
        if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) begin
            return b - CH_DIGIT_0;
        end
        if (b >= CH_LOWER_A && b <= CH_LOWER_F) begin
            return b - CH_LOWER_A + 8'd10;
        end
        if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
            return b - CH_UPPER_A + 8'd10;
        end
        return b;
    endfunction

endpackage

>>> hdl/pct_convert.sv
// Combinational conversion of one registered byte into up to three result bytes.
// Depends on pct_pkg for character constants, helper functions and types.
module pct_convert (
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic             i_mode,
    input  logic [63:0]      i_exclude,
    input  logic [63:0]      i_include,
    input  pct_pkg::t_state  i_state,
    output pct_pkg::t_result o_result,
    output pct_pkg::t_state  o_state
);
    import pct_pkg::*;

    logic       w_pass;
    logic [3:0] w_hi;
    logic [7:0] w_lo;

    always_comb begin
        w_pass = (is_unreserved(i_byte) || in_set(i_exclude, i_byte)) &&
                 !in_set(i_include, i_byte);
        w_hi = 4'(digit_value(i_state.held));
        w_lo = digit_value(i_byte);

        o_result = '0;
        o_state  = i_state;

        if (i_mode == MODE_ENCODE) begin
            if (w_pass) begin
                o_result.cnt      = 2'd1;
                o_result.bytes[0] = i_byte;
                o_result.lasts[0] = i_last;
            end else begin
                o_result.cnt      = 2'd3;
                o_result.bytes[0] = CH_PERCENT;
                o_result.bytes[1] = hex_char(i_byte[7:4]);
                o_result.bytes[2] = hex_char(i_byte[3:0]);
                o_result.lasts[2] = i_last;
            end
        end else begin
            case (i_state.phase)
                PH_PERCENT: begin
                    if (i_last) begin
                        o_result.cnt      = 2'd2;
                        o_result.bytes[0] = CH_PERCENT;
                        o_result.bytes[1] = i_byte;
                        o_result.lasts[1] = 1'b1;
                        o_state.phase     = PH_IDLE;
                        o_state.held      = 8'h00;
                    end else begin
                        o_state.phase = PH_DIGIT;
                        o_state.held  = i_byte;
                    end
                end
                PH_DIGIT: begin
                    o_result.cnt      = 2'd1;
                    o_result.bytes[0] = {w_hi, 4'h0} | w_lo;
                    o_result.lasts[0] = i_last;
                    o_state.phase     = PH_IDLE;
                    o_state.held      = 8'h00;
                end
                default: begin
                    o_state.phase = PH_IDLE;
                    if (i_byte == CH_PERCENT && !i_last) begin
                        o_state.phase = PH_PERCENT;
                    end else begin
                        o_result.cnt      = 2'd1;
                        o_result.bytes[0] = i_byte;
                        o_result.lasts[0] = i_last;
                    end
                end
            endcase
        end
    end

endmodule

>>> hdl/pct_expand.sv
// Result buffer that serializes up to three bytes into the output register.
// Depends on pct_pkg for the result type.
module pct_expand (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load_valid,
    output logic             o_load_ready,
    input  pct_pkg::t_result i_result,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,
    output logic             o_m_axis_tlast
);
    import pct_pkg::*;

    logic [1:0]              r_cnt;
    logic [MAX_RES-1:0][7:0] r_bytes;
    logic [MAX_RES-1:0]      r_lasts;
    logic                    r_out_valid;
    logic [7:0]              r_out_byte;
    logic                    r_out_last;
    logic                    w_out_load;
    logic                    w_buf_load;

    assign w_out_load   = (r_cnt != 2'd0) && (!r_out_valid || i_m_axis_tready);
    assign o_load_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_out_load);
    assign w_buf_load   = i_load_valid && o_load_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_buf_load) begin
                r_cnt <= i_result.cnt;
            end else if (w_out_load) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_byte <= r_bytes[0];
            r_out_last <= r_lasts[0];
        end
        if (w_buf_load) begin
            r_bytes <= i_result.bytes;
            r_lasts <= i_result.lasts;
        end else if (w_out_load) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                r_bytes[k] <= r_bytes[k+1];
                r_lasts[k] <= r_lasts[k+1];
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_last;

endmodule

>>> hdl/percent_codec_unit.sv
// Top level of the percent codec: configuration, input register and escape state.
// Depends on pct_pkg, pct_convert and pct_expand.
//
//  channel   direction  item
//  s_axis    in         tdata = in_byte, tlast = in_last
//  m_axis    out        tdata = out_byte, tlast = out_last
//  cfg       in         index 0 mode, 1 exclude set, 2 include set
//
// Result bytes leave one per cycle while m_axis tready is high, set by the single-byte
// output register; passed or decoded bytes yield one result byte, encoded bytes three.
// Accepted bytes pass the input register, the result buffer and the output register in turn.
// Reset clears the configuration, the escape state and all valid flags.
// A stalled output holds the buffer; the input register then fills and tready drops.
module percent_codec_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,   // in_byte
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [7:0]                        o_m_axis_tdata,   // out_byte
    output logic                              o_m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pct_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [63:0]                       i_cfg_data
);
    import pct_pkg::*;

    logic        r_mode;
    logic [63:0] r_exclude;
    logic [63:0] r_include;
    t_state      r_state;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    t_result     w_result;
    t_state      n_state;
    logic        w_take;
    logic        w_cfg_wr;

    assign o_cfg_ready     = 1'b1;
    assign w_cfg_wr        = i_cfg_valid && o_cfg_ready;
    assign o_s_axis_tready = !r_in_valid || w_take;

    pct_convert u_convert (
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_mode    (r_mode),
        .i_exclude (r_exclude),
        .i_include (r_include),
        .i_state   (r_state),
        .o_result  (w_result),
        .o_state   (n_state)
    );

    pct_expand u_expand (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load_valid    (r_in_valid),
        .o_load_ready    (w_take),
        .i_result        (w_result),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_ENCODE;
            r_exclude  <= '0;
            r_include  <= '0;
            r_state    <= '{phase: PH_IDLE, held: 8'h00};
            r_in_valid <= 1'b0;
        end else begin
            if (w_cfg_wr && i_cfg_index == CFG_MODE) begin
                r_mode  <= i_cfg_data[0];
                r_state <= '{phase: PH_IDLE, held: 8'h00};
            end else if (r_in_valid && w_take) begin
                r_state <= n_state;
            end
            if (w_cfg_wr && i_cfg_index == CFG_EXCLUDE) begin
                r_exclude <= i_cfg_data;
            end
            if (w_cfg_wr && i_cfg_index == CFG_INCLUDE) begin
                r_include <= i_cfg_data;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

endmodule

>>> hdl/pct_checker.sv
// Port-level checker for the percent codec, bound to the top level.
// Depends on percent_codec_unit_macros.svh.
`include "percent_codec_unit_macros.svh"

module pct_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast
);

    logic       w_hold;
    logic [8:0] w_item;

    assign w_hold = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_item = {o_m_axis_tlast, o_m_axis_tdata};

    // After reset the input register is empty and the output is idle.
    `PCT_ASSERT_ALWAYS(a_reset_ready, $past(!i_rst_n) |-> o_s_axis_tready, "not ready after reset")
    `PCT_ASSERT_ALWAYS(a_reset_idle, $past(!i_rst_n) |-> !o_m_axis_tvalid, "valid after reset")

    // Back pressure on the input only arises while results are pending.
    `PCT_ASSERT(a_stall_has_output, !o_s_axis_tready |=> o_m_axis_tvalid, "stall without output")

    `PCT_ASSERT(a_out_hold, w_hold |=> o_m_axis_tvalid && $stable(w_item), "stalled item changed")

endmodule

bind percent_codec_unit pct_checker u_pct_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench of percent_codec_unit: encodes and decodes byte strings and
// compares every output item with a predictor of its own. Depends on pct_pkg.
`timescale 1ns / 1ps

module testbench;
    import pct_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_REPORTS   = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_coded_byte;

    logic                 i_clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic [7:0]           s_data = 8'h00;
    logic                 s_last = 1'b0;
    logic                 m_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;

    logic                 s_ready;
    logic                 m_valid;
    logic [7:0]           m_data;
    logic                 m_last;
    logic                 cfg_ready;

    // Copy of the block's configuration and escape state.
    logic        cur_mode = MODE_ENCODE;
    logic [63:0] never_set = '0;
    logic [63:0] always_set = '0;
    t_phase      esc_phase = PH_IDLE;
    logic [7:0]  esc_held = 8'h00;

    t_coded_byte coded_bytes_q[$];
    int          bad_bytes = 0;
    int          bytes_fed = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    int          stall_style = 0;

    percent_codec_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit url_safe(input logic [7:0] b);
        return (b >= CH_LOWER_A && b <= CH_LOWER_Z) || (b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
               (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) || b == CH_DASH || b == CH_DOT ||
               b == CH_UNDER || b == CH_TILDE;
    endfunction

    function automatic bit set_has(input logic [63:0] set, input logic [7:0] b);
        bit hit;
        hit = 1'b0;
        for (int k = 0; k < SET_SLOTS; k++) begin
            if (b != 8'h00 && set[8*k +: 8] == b) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return (nib < 4'd10) ? CH_DIGIT_0 + 8'(nib) : CH_UPPER_A + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] nibble_of(input logic [7:0] b);
        if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) begin
            return b - CH_DIGIT_0;
        end
        if (b >= CH_LOWER_A && b <= CH_LOWER_F) begin
            return b - CH_LOWER_A + 8'd10;
        end
        if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
            return b - CH_UPPER_A + 8'd10;
        end
        return b;
    endfunction

    function automatic void push_coded(input logic [7:0] b, input logic l);
        t_coded_byte c;
        c.data = b;
        c.last = l;
        coded_bytes_q.push_back(c);
    endfunction

    function automatic void code_byte(input logic [7:0] b, input logic l);
        logic [7:0] val;
        if (cur_mode == MODE_ENCODE) begin
            if ((url_safe(b) || set_has(never_set, b)) && !set_has(always_set, b)) begin
                push_coded(b, l);
            end else begin
                push_coded(CH_PERCENT, 1'b0);
                push_coded(hex_digit(b[7:4]), 1'b0);
                push_coded(hex_digit(b[3:0]), l);
            end
            return;
        end
        case (esc_phase)
            PH_PERCENT: begin
                if (l) begin
                    esc_phase = PH_IDLE;
                    esc_held  = 8'h00;
                    push_coded(CH_PERCENT, 1'b0);
                    push_coded(b, 1'b1);
                end else begin
                    esc_held  = b;
                    esc_phase = PH_DIGIT;
                end
            end
            PH_DIGIT: begin
                val = (nibble_of(esc_held) << 4) | nibble_of(b);
                esc_phase = PH_IDLE;
                esc_held  = 8'h00;
                push_coded(val, l);
            end
            default: begin
                esc_phase = PH_IDLE;
                if (b == CH_PERCENT && !l) begin
                    esc_phase = PH_PERCENT;
                end else begin
                    push_coded(b, l);
                end
            end
        endcase
    endfunction

    function automatic logic [63:0] pick_set();
        logic [63:0] s;
        for (int k = 0; k < SET_SLOTS; k++) begin
            case ($urandom_range(0, 3))
                0:       s[8*k +: 8] = 8'h00;
                1:       s[8*k +: 8] = 8'($urandom_range(8'h20, 8'h7E));
                default: s[8*k +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return s;
    endfunction

    function automatic logic [7:0] pick_hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) begin
            return CH_DIGIT_0 + 8'(r);
        end
        if (r < 16) begin
            return CH_LOWER_A + 8'(r - 10);
        end
        return CH_UPPER_A + 8'(r - 16);
    endfunction

    function automatic logic [7:0] pick_text_byte();
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
            1: return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
            2: return 8'($urandom_range(CH_DIGIT_0, CH_DIGIT_9));
            3: begin
                case ($urandom_range(0, 3))
                    0:       return CH_DASH;
                    1:       return CH_DOT;
                    2:       return CH_UNDER;
                    default: return CH_TILDE;
                endcase
            end
            4: return never_set[8*$urandom_range(0, 7) +: 8];
            5: return always_set[8*$urandom_range(0, 7) +: 8];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic feed_byte(input logic [7:0] b, input logic l);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= l;
        do @(posedge i_clk); while (!s_ready);
        code_byte(b, l);
        burst_left--;
        bytes_fed++;
    endtask

    task automatic feed_string(input string text, input logic end_mark);
        for (int k = 0; k < text.len(); k++) begin
            feed_byte(text[k], (k == text.len() - 1) ? end_mark : 1'b0);
        end
    endtask

    // Lets every result drain and any escape byte without a result leave the pipeline.
    task automatic settle();
        s_valid <= 1'b0;
        while (coded_bytes_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE: begin
                cur_mode  = value[0];
                esc_phase = PH_IDLE;
                esc_held  = 8'h00;
            end
            CFG_EXCLUDE: never_set = value;
            CFG_INCLUDE: always_set = value;
            default: ;
        endcase
    endtask

    task automatic test_encode_basics();
        feed_byte(8'h00, 1'b0);
        feed_byte(8'hFF, 1'b0);
        feed_string("zA9-._~/", 1'b0);
        feed_byte(CH_PERCENT, 1'b1);
    endtask

    task automatic test_char_sets();
        settle();
        write_reg(CFG_EXCLUDE, 64'hFF00_0000_0000_3A2F);
        write_reg(CFG_INCLUDE, 64'h0000_0000_0000_612F);
        write_reg(CFG_UNUSED, '1);
        feed_string("/:a", 1'b0);
        feed_byte(8'hFF, 1'b0);
        feed_byte(8'h00, 1'b1);
        settle();
        write_reg(CFG_EXCLUDE, '0);
        write_reg(CFG_INCLUDE, '1);
        feed_byte(8'hFF, 1'b0);
        feed_byte(CH_LOWER_A + 8'd1, 1'b1);
    endtask

    task automatic test_decode_basics();
        settle();
        write_reg(CFG_MODE, MODE_DECODE);
        feed_string("%4a%zq", 1'b1);
        feed_byte(CH_PERCENT, 1'b1);
        feed_string("%x", 1'b1);
        feed_string("%%GQ", 1'b1);
        // A mode write in the middle of an escape drops the pending percent sign.
        feed_byte(CH_PERCENT, 1'b0);
        settle();
        write_reg(CFG_MODE, MODE_DECODE);
        feed_string("41", 1'b1);
    endtask

    task automatic test_random_encode();
        int stop_at;
        for (int round = 0; round < 3; round++) begin
            settle();
            write_reg(CFG_MODE, MODE_ENCODE);
            write_reg(CFG_EXCLUDE, (round == 2) ? '1 : pick_set());
            write_reg(CFG_INCLUDE, (round == 0) ? '0 : pick_set());
            stop_at = bytes_fed + 37;
            while (bytes_fed < stop_at) begin
                feed_byte(pick_text_byte(), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    task automatic test_random_decode();
        int stop_at;
        int len;
        logic end_mark;
        for (int round = 0; round < 2; round++) begin
            settle();
            write_reg(CFG_MODE, MODE_DECODE);
            write_reg(CFG_EXCLUDE, pick_set());
            write_reg(CFG_INCLUDE, pick_set());
            stop_at = bytes_fed + 90;
            while (bytes_fed < stop_at) begin
                end_mark = ($urandom_range(0, 4) == 0);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        feed_byte(CH_PERCENT, 1'b0);
                        feed_byte(pick_hex_char(), 1'b0);
                        feed_byte(pick_hex_char(), end_mark);
                    end
                    6, 7: begin
                        len = $urandom_range(1, 4);
                        for (int k = 0; k < len; k++) begin
                            feed_byte(8'($urandom_range(0, 255)),
                                      (k == len - 1) ? end_mark : 1'b0);
                        end
                    end
                    8: begin
                        feed_byte(CH_PERCENT, 1'b0);
                        feed_byte(8'($urandom_range(0, 255)), 1'b0);
                        feed_byte(8'($urandom_range(0, 255)), end_mark);
                    end
                    default: begin
                        if ($urandom_range(0, 1) == 0) begin
                            feed_byte(CH_PERCENT, 1'b1);
                        end else begin
                            feed_byte(CH_PERCENT, 1'b0);
                            feed_byte(8'($urandom_range(0, 255)), 1'b1);
                        end
                    end
                endcase
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_encode_basics();
        test_char_sets();
        test_decode_basics();
        test_random_encode();
        test_random_decode();
        s_valid <= 1'b0;
        while (coded_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_bytes == 0 && coded_bytes_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // The receiver switches between steady, busy, sparse and periodic stall styles.
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(32, 96);
        end
        stall_left--;
        case (stall_style)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 3) != 0);
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (stall_left % 5) < 2;
        endcase
    end

    always @(posedge i_clk) begin
        t_coded_byte want;
        if (rst_n && m_valid && m_ready) begin
            if (coded_bytes_q.size() == 0) begin
                if (bad_bytes < MAX_REPORTS) begin
                    $display("Unexpected output item: data %h last %b", m_data, m_last);
                end
                bad_bytes++;
            end else begin
                want = coded_bytes_q.pop_front();
                if (want.data !== m_data || want.last !== m_last) begin
                    if (bad_bytes < MAX_REPORTS) begin
                        $display("Output mismatch: expected data %h last %b, got data %h last %b",
                                 want.data, want.last, m_data, m_last);
                    end
                    bad_bytes++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
